>>> hw/rtl/string_bucket_hash_assert.svh
// ----------------------------------------------------------------------------
// string_bucket_hash_assert.svh
// Assertion macros shared by the name hasher RTL.
// ----------------------------------------------------------------------------
`ifndef STRING_BUCKET_HASH_ASSERT_SVH
`define STRING_BUCKET_HASH_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define SBH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define SBH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sbh_pkg.sv
// ----------------------------------------------------------------------------
// sbh_pkg
// Types and constants shared by the name hasher modules.
// ----------------------------------------------------------------------------
package sbh_pkg;

   localparam int HASH_W      = 32;
   localparam int BUCKET_W    = 16;
   localparam int BCOUNT_W    = 17;
   localparam int CHAR_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = BCOUNT_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;
   localparam int STEP_W      = 5;

   // Hash mixing shifts
   localparam int SHIFT_LO = 3;
   localparam int SHIFT_HI = 28;

   // Character constants
   localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
   localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   // Bucket count limits
   localparam logic [BCOUNT_W-1:0] MAX_BUCKETS = 17'h10000;
   localparam logic [BCOUNT_W-1:0] MIN_BUCKETS = 17'h00001;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_CASE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_CHARS = 2'd2;

   typedef logic [HASH_W-1:0]   hash_type;
   typedef logic [BUCKET_W-1:0] bucket_type;
   typedef logic [BCOUNT_W-1:0] bcount_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

>>> hw/rtl/sbh_front.sv
// ----------------------------------------------------------------------------
// sbh_front
// Accepts characters, folds and extends them, and runs the hash accumulator.
// A terminating zero pushes the finished hash into the queue.
// ----------------------------------------------------------------------------
module sbh_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sbh_pkg::CHAR_W-1:0]  req_ch,
   input  logic                        fold_case,
   input  logic                        signed_chars,
   input  sbh_pkg::q_stat_type         q_stat,
   output logic                        push,
   output sbh_pkg::hash_type           push_hash
);
   import sbh_pkg::*;

   hash_type          acc_ff;
   hash_type          acc_in;
   hash_type          term;
   logic [CHAR_W-1:0] folded;
   logic              accept;

   // Hold input while the queue cannot take a finished name
   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   // Fold case, then sign-extend or zero-extend the byte
   always_comb begin
      folded = req_ch;
      if (fold_case && (req_ch >= CH_UPPER_A) && (req_ch <= CH_UPPER_Z)) begin
         folded = req_ch + CASE_OFFSET;
      end
      if (signed_chars) begin
         term = {{(HASH_W-CHAR_W){folded[CHAR_W-1]}}, folded};
      end else begin
         term = {{(HASH_W-CHAR_W){1'b0}}, folded};
      end
   end

   // Advance the accumulator on a character, clear it on the terminator
   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         if (req_ch == CH_NUL) begin
            acc_in = '0;
         end else begin
            acc_in = acc_ff + (acc_ff << SHIFT_LO) + (acc_ff >> SHIFT_HI) + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign push      = accept && (req_ch == CH_NUL);
   assign push_hash = acc_ff;

endmodule

>>> hw/rtl/sbh_queue.sv
// ----------------------------------------------------------------------------
// sbh_queue
// Two-entry queue of finished hashes between the front and the back.
// ----------------------------------------------------------------------------
`include "string_bucket_hash_assert.svh"

module sbh_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sbh_pkg::hash_type    push_hash,
   input  logic                 pop,
   output sbh_pkg::hash_type    pop_hash,
   output sbh_pkg::q_stat_type  q_stat
);
   import sbh_pkg::*;

   hash_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed hash
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_hash;
      end
   end

   assign pop_hash     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   `SBH_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `SBH_ASSERT_IMP(a_no_push_full, clock, reset, push, !q_stat.full, "push into full queue")

endmodule

>>> hw/rtl/sbh_back.sv
// ----------------------------------------------------------------------------
// sbh_back
// Reduces each queued hash modulo the bucket count, one quotient bit per
// cycle, and presents the result in an output register.
// ----------------------------------------------------------------------------
`include "string_bucket_hash_assert.svh"

module sbh_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sbh_pkg::bcount_type           bucket_count,
   input  sbh_pkg::q_stat_type           q_stat,
   input  sbh_pkg::hash_type             pop_hash,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sbh_pkg::BUCKET_W-1:0]  rsp_bucket,
   output logic [sbh_pkg::HASH_W-1:0]    rsp_hash_value
);
   import sbh_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   hash_type          hash_ff;
   hash_type          hash_in;
   hash_type          quo_ff;
   hash_type          quo_in;
   bucket_type        rem_ff;
   bucket_type        rem_in;
   bcount_type        divisor;
   bcount_type        rem_shift;
   logic              out_free;
   logic              out_load;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   bucket_type        rsp_bucket_ff;
   hash_type          rsp_hash_ff;

   // Clamp the bucket count into 1..65536
   always_comb begin
      divisor = bucket_count;
      if (bucket_count == '0) begin
         divisor = MIN_BUCKETS;
      end else if (bucket_count > MAX_BUCKETS) begin
         divisor = MAX_BUCKETS;
      end
   end

   // One restoring division step
   assign rem_shift = {rem_ff, quo_ff[HASH_W-1]};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequence load, divide and hand-off
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      hash_in  = hash_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      pop      = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               hash_in  = pop_hash;
               quo_in   = pop_hash;
               rem_in   = '0;
               step_in  = STEP_W'(HASH_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in = quo_ff << 1;
            if (rem_shift >= divisor) begin
               rem_in = BUCKET_W'(rem_shift - divisor);
            end else begin
               rem_in = BUCKET_W'(rem_shift);
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      hash_ff <= hash_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   // Output register: hold until the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_bucket_ff <= rem_ff;
         rsp_hash_ff   <= hash_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bucket     = rsp_bucket_ff;
   assign rsp_hash_value = rsp_hash_ff;

   `SBH_ASSERT_IMP(a_rem_below_div, clock, reset, state_ff == ST_DIV,
      {1'b0, rem_ff} < divisor, "partial remainder not below divisor")
   `SBH_ASSERT_NXT(a_pop_starts_div, clock, reset, pop,
      state_ff == ST_DIV && step_ff == STEP_W'(HASH_W - 1), "pop did not start a division")

endmodule

>>> hw/rtl/string_bucket_hash.sv
// ----------------------------------------------------------------------------
// string_bucket_hash
// Streaming name hasher with bucket reduction.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and folds it into a 32-bit hash.
// A zero character closes the name: the hash goes into a two-entry queue and
// the accumulator clears, so the next name can start in the very next cycle.
// A back-end divider reduces each queued hash modulo the bucket count one
// quotient bit per cycle; each finished name passes through a queue pop,
// 32 divide steps and a hand-off to the output register before its
// beat appears on rsp_. Characters keep flowing at one per cycle until the
// queue holds two names that the divider has not yet taken; then req_stall
// rises. Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
module string_bucket_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sbh_pkg::CHAR_W-1:0]      req_ch,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sbh_pkg::BUCKET_W-1:0]    rsp_bucket,
   output logic [sbh_pkg::HASH_W-1:0]      rsp_hash_value,
   input  logic                            csr_we,
   input  logic [sbh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbh_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sbh_pkg::*;

   bcount_type bucket_count_ff;
   logic       fold_case_ff;
   logic       signed_chars_ff;
   q_stat_type q_stat;
   logic       push;
   hash_type   push_hash;
   logic       pop;
   hash_type   pop_hash;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BCOUNT_W'(256);
         fold_case_ff    <= 1'b0;
         signed_chars_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BUCKET_COUNT: bucket_count_ff <= csr_wdata;
            CSR_FOLD_CASE:    fold_case_ff    <= csr_wdata[0];
            CSR_SIGNED_CHARS: signed_chars_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   sbh_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_ch       (req_ch),
      .fold_case    (fold_case_ff),
      .signed_chars (signed_chars_ff),
      .q_stat       (q_stat),
      .push         (push),
      .push_hash    (push_hash)
   );

   sbh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_hash (push_hash),
      .pop       (pop),
      .pop_hash  (pop_hash),
      .q_stat    (q_stat)
   );

   sbh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .bucket_count   (bucket_count_ff),
      .q_stat         (q_stat),
      .pop_hash       (pop_hash),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bucket     (rsp_bucket),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
